// ===== hdl/ard_pkg.sv =====
`timescale 1ns / 1ps

package ard_pkg;

    // Table geometry. CAPACITY must be a power of two: the probe pointer
    // wraps by dropping its carry and the home slot is a bit field of the base.
    localparam int CAPACITY   = 64;
    localparam int HASH_SHIFT = 4;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Field widths.
    localparam int FUNC_W = 2;
    localparam int ADDR_W = 48;
    localparam int LEN_W  = 48;
    localparam int TAG_W  = 16;

    // Request codes.
    localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNREGISTER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 2'd2;

    // One table entry as stored in the slot memory.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  length;
        logic [TAG_W-1:0]  front;
        logic [TAG_W-1:0]  cls;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/ard_ram.sv =====
`timescale 1ns / 1ps

// Generic simple dual-port RAM: one write port, one read port with a
// registered read. A read of an address written in the same cycle
// returns the old contents.
module ard_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/address_range_directory_core.sv =====
`timescale 1ns / 1ps

// A request that needs no table access goes straight to its result; any other
// visits slots in turn until it is settled (at most CAPACITY slots), one slot
// per cycle through the slot memory read port.
// Throughput: one request at a time.
// Reset: asynchronous, active low; every slot reads as empty at once through
// per-slot occupied bits, so no clearing pass is needed.
module address_range_directory_core
    import ard_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [ADDR_W-1:0] address,
    input  logic [LEN_W-1:0]  length,
    input  logic [TAG_W-1:0]  front_tag,
    input  logic [TAG_W-1:0]  class_tag,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              ok,
    output logic [TAG_W-1:0]  hit_front,
    output logic [TAG_W-1:0]  hit_class
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Captured request.
    logic [FUNC_W-1:0] func_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [TAG_W-1:0]  front_reg;
    logic [TAG_W-1:0]  class_reg;

    // Read issue side of the scan.
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;

    // Check side of the scan: the slot whose data arrives this cycle.
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             chk_last_reg, chk_last_next;

    // Occupied bit per slot.
    logic [CAPACITY-1:0] used_reg, used_next;

    // Pending result and output beat.
    logic             res_ok_reg, res_ok_next;
    logic [TAG_W-1:0] res_front_reg, res_front_next;
    logic [TAG_W-1:0] res_class_reg, res_class_next;
    logic             out_valid_reg, out_valid_next;
    logic             ok_reg;
    logic [TAG_W-1:0] hit_front_reg;
    logic [TAG_W-1:0] hit_class_reg;

    // Memory interface.
    logic             wr_en;
    entry_t           wr_entry;
    entry_t           rd_entry;
    logic [ENTRY_W-1:0] rd_data;

    logic             in_accept;
    logic             trivial;
    logic             out_free;
    logic             slot_used;
    logic             base_match;
    logic             in_range;
    logic [ADDR_W:0]  range_end;

    ard_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (chk_idx_reg),
        .wr_data (wr_entry),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign hit_front = hit_front_reg;
    assign hit_class = hit_class_reg;

    // Requests that finish without touching the table.
    always_comb
    begin
        unique case (func)
            FUNC_REGISTER:   trivial = (address == '0) || (length == '0);
            FUNC_UNREGISTER: trivial = (address == '0);
            FUNC_LOOKUP:     trivial = (address == '0);
            default:         trivial = 1'b1;
        endcase
    end

    // Slot tests for the entry under check.
    assign slot_used  = used_reg[chk_idx_reg];
    assign base_match = (rd_entry.base == addr_reg);
    assign range_end  = {1'b0, rd_entry.base} + {1'b0, rd_entry.length};
    assign in_range   = (rd_entry.length != '0) && (addr_reg >= rd_entry.base)
                        && ({1'b0, addr_reg} < range_end);

    assign wr_entry.base   = addr_reg;
    assign wr_entry.length = len_reg;
    assign wr_entry.front  = front_reg;
    assign wr_entry.cls    = class_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        iss_cnt_next   = iss_cnt_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        chk_last_next  = chk_last_reg;
        used_next      = used_reg;
        res_ok_next    = res_ok_reg;
        res_front_next = res_front_reg;
        res_class_next = res_class_reg;
        out_valid_next = out_valid_reg && out_stall;
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_ok_next    = 1'b0;
                    res_front_next = '0;
                    res_class_next = '0;
                    iss_cnt_next   = '0;
                    if (func == FUNC_LOOKUP)
                    begin
                        ptr_next = '0;
                    end
                    else
                    begin
                        ptr_next = address[HASH_SHIFT +: IDX_W];
                    end
                    state_next = trivial ? ST_DONE : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue the next slot read while slots remain on the path.
                if (iss_cnt_reg != CNT_W'(CAPACITY))
                begin
                    ptr_next       = ptr_reg + 1'b1;
                    iss_cnt_next   = iss_cnt_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = ptr_reg;
                    chk_last_next  = (iss_cnt_reg == CNT_W'(CAPACITY - 1));
                end

                // Check the slot whose data is back from memory.
                if (chk_valid_reg)
                begin
                    unique case (func_reg)
                        FUNC_REGISTER:
                        begin
                            if (!slot_used)
                            begin
                                wr_en                  = 1'b1;
                                used_next[chk_idx_reg] = 1'b1;
                                res_ok_next            = 1'b1;
                                state_next             = ST_DONE;
                            end
                            else if (base_match || chk_last_reg)
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        FUNC_UNREGISTER:
                        begin
                            if (slot_used && base_match)
                            begin
                                used_next[chk_idx_reg] = 1'b0;
                                state_next             = ST_DONE;
                            end
                            else if (!slot_used || chk_last_reg)
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            if (slot_used && in_range)
                            begin
                                res_ok_next    = 1'b1;
                                res_front_next = rd_entry.front;
                                res_class_next = rd_entry.cls;
                                state_next     = ST_DONE;
                            end
                            else if (chk_last_reg)
                            begin
                                state_next = ST_DONE;
                            end
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            iss_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            iss_cnt_reg   <= iss_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg  <= func;
            addr_reg  <= address;
            len_reg   <= length;
            front_reg <= front_tag;
            class_reg <= class_tag;
        end
        ptr_reg       <= ptr_next;
        chk_idx_reg   <= chk_idx_next;
        chk_last_reg  <= chk_last_next;
        res_ok_reg    <= res_ok_next;
        res_front_reg <= res_front_next;
        res_class_reg <= res_class_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            ok_reg        <= res_ok_reg;
            hit_front_reg <= res_front_reg;
            hit_class_reg <= res_class_reg;
        end
    end

endmodule

// ===== dv/tb_address_range_directory_core.sv =====
`timescale 1ns / 1ps

module tb_address_range_directory_core;
    import ard_pkg::*;

    // Code 3 has no name in the package; the block treats it as a no-op.
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    localparam int RANDOM_ITEMS   = 360;
    localparam int FILL_COUNT     = CAPACITY + 6;
    localparam int POOL_SIZE      = 40;
    localparam int IDLE_PERCENT   = 6;
    localparam int QUIET_FIRST    = 150;
    localparam int QUIET_LAST     = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 16;
    localparam int HI_W           = ADDR_W - IDX_W - HASH_SHIFT;

    localparam logic [ADDR_W-1:0] ADDR_ONES   = {ADDR_W{1'b1}};
    localparam logic [LEN_W-1:0]  LEN_ONES    = {LEN_W{1'b1}};
    localparam logic [TAG_W-1:0]  TAG_ONES    = {TAG_W{1'b1}};
    localparam logic [ADDR_W-1:0] BASE_A      = 48'h0000_0000_1000;
    localparam logic [ADDR_W-1:0] BASE_B      = 48'h0000_0000_1400;
    localparam logic [ADDR_W-1:0] FILL_REGION = 48'h5A5A_0000_0000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [TAG_W-1:0]  front;
        logic [TAG_W-1:0]  cls;
    } dir_request_t;

    typedef struct packed {
        logic             ok;
        logic [TAG_W-1:0] front;
        logic [TAG_W-1:0] cls;
    } dir_reply_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [FUNC_W-1:0] func      = '0;
    logic [ADDR_W-1:0] address   = '0;
    logic [LEN_W-1:0]  length    = '0;
    logic [TAG_W-1:0]  front_tag = '0;
    logic [TAG_W-1:0]  class_tag = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              ok;
    logic [TAG_W-1:0]  hit_front;
    logic [TAG_W-1:0]  hit_class;

    // Shadow copy of the range table.
    logic [ADDR_W-1:0] dir_base  [CAPACITY];
    logic [LEN_W-1:0]  dir_len   [CAPACITY];
    logic [TAG_W-1:0]  dir_front [CAPACITY];
    logic [TAG_W-1:0]  dir_class [CAPACITY];

    dir_request_t      pending_requests[$];
    dir_reply_t        predicted_replies[$];
    logic [ADDR_W-1:0] base_pool[POOL_SIZE];

    int issued_count   = 0;
    int accepted_count = 0;
    int reply_count    = 0;
    int error_count    = 0;
    int idle_cycles    = 0;

    address_range_directory_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .address   (address),
        .length    (length),
        .front_tag (front_tag),
        .class_tag (class_tag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .hit_front (hit_front),
        .hit_class (hit_class)
    );

    always #6 clk = ~clk;

    // Home slot of a base on the probe path.
    function automatic int home_slot_of(logic [ADDR_W-1:0] base);
        return int'((base >> HASH_SHIFT) % ADDR_W'(CAPACITY));
    endfunction

    // Applies one request to the shadow table and returns the reply it earns.
    function automatic dir_reply_t directory_predict(dir_request_t req);
        dir_reply_t       reply;
        int               start;
        int               slot;
        logic [ADDR_W:0]  range_end;
        reply = '0;
        case (req.func)
            FUNC_REGISTER:
            begin
                if (req.address == '0 || req.length == '0)
                    return reply;
                start = home_slot_of(req.address);
                for (int p = 0; p < CAPACITY; p++)
                begin
                    slot = (start + p) % CAPACITY;
                    if (dir_base[slot] == req.address)
                        return reply;
                    if (dir_base[slot] == '0)
                    begin
                        dir_base[slot]  = req.address;
                        dir_len[slot]   = req.length;
                        dir_front[slot] = req.front;
                        dir_class[slot] = req.cls;
                        reply.ok = 1'b1;
                        return reply;
                    end
                end
            end
            FUNC_UNREGISTER:
            begin
                if (req.address == '0)
                    return reply;
                start = home_slot_of(req.address);
                for (int p = 0; p < CAPACITY; p++)
                begin
                    slot = (start + p) % CAPACITY;
                    if (dir_base[slot] == '0)
                        return reply;
                    if (dir_base[slot] == req.address)
                    begin
                        dir_base[slot]  = '0;
                        dir_len[slot]   = '0;
                        dir_front[slot] = '0;
                        dir_class[slot] = '0;
                        return reply;
                    end
                end
            end
            FUNC_LOOKUP:
            begin
                if (req.address == '0)
                    return reply;
                // Scan in index order; the range end never wraps.
                for (int s = 0; s < CAPACITY; s++)
                begin
                    range_end = {1'b0, dir_base[s]} + {1'b0, dir_len[s]};
                    if (dir_base[s] != '0 && dir_len[s] != '0 &&
                        req.address >= dir_base[s] && {1'b0, req.address} < range_end)
                    begin
                        reply.ok    = 1'b1;
                        reply.front = dir_front[s];
                        reply.cls   = dir_class[s];
                        return reply;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return reply;
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [ADDR_W-1:0] pooled_base();
        return base_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Mostly short ranges so that neighbors overlap, with the odd extreme.
    function automatic logic [LEN_W-1:0] random_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return LEN_ONES;
        if (roll < 20)
            return LEN_W'({$urandom(), $urandom()});
        return LEN_W'($urandom_range(1, 'h400));
    endfunction

    function automatic logic [ADDR_W-1:0] probe_near(logic [ADDR_W-1:0] base);
        return base + ADDR_W'($urandom_range(0, 'h300));
    endfunction

    task automatic queue_request(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                 logic [LEN_W-1:0] l, logic [TAG_W-1:0] ft,
                                 logic [TAG_W-1:0] ct);
        dir_request_t req;
        req.func    = f;
        req.address = a;
        req.length  = l;
        req.front   = ft;
        req.cls     = ct;
        pending_requests.push_back(req);
    endtask

    // Request driver: holds a beat until it is taken, idles now and then.
    always @(negedge clk)
    begin
        dir_request_t req;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || accepted_count == issued_count)
        begin
            if (pending_requests.size() != 0 &&
                ((issued_count >= QUIET_FIRST && issued_count < QUIET_LAST) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT))
            begin
                req = pending_requests.pop_front();
                in_valid  <= 1'b1;
                func      <= req.func;
                address   <= req.address;
                length    <= req.length;
                front_tag <= req.front;
                class_tag <= req.cls;
                issued_count++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Reply side back-pressure.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (reply_count >= QUIET_FIRST && reply_count < QUIET_LAST)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Monitor: predicts on each request beat, checks each reply beat, and
    // watches for a hung handshake.
    always @(posedge clk)
    begin
        dir_request_t req;
        dir_reply_t   want;
        logic         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                req.func    = func;
                req.address = address;
                req.length  = length;
                req.front   = front_tag;
                req.cls     = class_tag;
                predicted_replies.push_back(directory_predict(req));
                accepted_count++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                reply_count++;
                moved = 1'b1;
                if (predicted_replies.size() == 0)
                begin
                    $display("%0t: reply with none expected: ok %0d front %h class %h",
                             $time, ok, hit_front, hit_class);
                    error_count++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (ok !== want.ok)
                    begin
                        $display("%0t: ok mismatch: expected %0d, actual %0d",
                                 $time, want.ok, ok);
                        error_count++;
                    end
                    if (hit_front !== want.front)
                    begin
                        $display("%0t: hit_front mismatch: expected %h, actual %h",
                                 $time, want.front, hit_front);
                        error_count++;
                    end
                    if (hit_class !== want.cls)
                    begin
                        $display("%0t: hit_class mismatch: expected %h, actual %h",
                                 $time, want.cls, hit_class);
                        error_count++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("address_range_directory_core regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [HI_W-1:0]  region_hi[4];
        logic [IDX_W-1:0] home;
        logic [ADDR_W-1:0] base;
        int               roll;

        for (int s = 0; s < CAPACITY; s++)
        begin
            dir_base[s]  = '0;
            dir_len[s]   = '0;
            dir_front[s] = '0;
            dir_class[s] = '0;
        end

        // Bases share a few upper regions and crowd a handful of home slots,
        // some near the top so that probes wrap.
        for (int r = 0; r < 4; r++)
            region_hi[r] = HI_W'({$urandom(), $urandom()}) | HI_W'(1);
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            home = (k % 4 == 0) ? IDX_W'($urandom_range(CAPACITY - 4, CAPACITY - 1))
                                : IDX_W'($urandom_range(0, 11));
            base_pool[k] = {region_hi[$urandom_range(0, 3)], home,
                            HASH_SHIFT'($urandom_range(0, (1 << HASH_SHIFT) - 1))};
        end

        // Directed: null and zero-length cases, duplicates, a hole on the
        // probe path, containment bounds, the top of the address space.
        queue_request(FUNC_LOOKUP, '0, '0, '0, '0);
        queue_request(FUNC_LOOKUP, BASE_A, '0, '0, '0);
        queue_request(FUNC_REGISTER, '0, 48'h10, 16'h1111, 16'h2222);
        queue_request(FUNC_REGISTER, BASE_A, '0, 16'h1111, 16'h2222);
        queue_request(FUNC_REGISTER, BASE_A, 48'h100, TAG_ONES, '0);
        queue_request(FUNC_REGISTER, BASE_A, 48'h40, 16'h0001, 16'h0002);
        queue_request(FUNC_REGISTER, BASE_B, 48'h20, '0, TAG_ONES);
        queue_request(FUNC_LOOKUP, BASE_A, '0, '0, '0);
        queue_request(FUNC_LOOKUP, BASE_A + 48'hFF, '0, '0, '0);
        queue_request(FUNC_LOOKUP, BASE_A + 48'h100, '0, '0, '0);
        queue_request(FUNC_LOOKUP, BASE_A - 48'h1, '0, '0, '0);
        queue_request(FUNC_LOOKUP, BASE_B + 48'h10, '0, '0, '0);
        queue_request(FUNC_UNREGISTER, '0, LEN_ONES, TAG_ONES, TAG_ONES);
        queue_request(FUNC_UNREGISTER, 48'h2000, '0, '0, '0);
        queue_request(FUNC_UNREGISTER, BASE_A, '0, '0, '0);
        queue_request(FUNC_REGISTER, BASE_B, 48'h8, 16'h1234, 16'h5678);
        queue_request(FUNC_LOOKUP, BASE_B + 48'h4, '0, '0, '0);
        queue_request(FUNC_LOOKUP, BASE_B + 48'h10, '0, '0, '0);
        queue_request(FUNC_REGISTER, ADDR_ONES, LEN_ONES, TAG_ONES, TAG_ONES);
        queue_request(FUNC_LOOKUP, ADDR_ONES, '0, '0, '0);
        queue_request(FUNC_LOOKUP, 48'h8000_0000_0000, '0, '0, '0);
        queue_request(FUNC_NOP, ADDR_ONES, LEN_ONES, TAG_ONES, TAG_ONES);
        queue_request(FUNC_UNREGISTER, ADDR_ONES, '0, '0, '0);
        queue_request(FUNC_LOOKUP, ADDR_ONES, '0, '0, '0);
        queue_request(FUNC_UNREGISTER, BASE_B, '0, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Midway, fill the table to overflow, probe it full, then empty it.
            if (n == RANDOM_ITEMS / 2)
            begin
                for (int k = 0; k < FILL_COUNT; k++)
                    queue_request(FUNC_REGISTER, FILL_REGION | ADDR_W'(k << HASH_SHIFT) | 9,
                                  random_length(), TAG_W'($urandom()), TAG_W'($urandom()));
                queue_request(FUNC_REGISTER, FILL_REGION | 8, 48'h10, 16'hAAAA, 16'h5555);
                queue_request(FUNC_UNREGISTER, FILL_REGION | 8, '0, '0, '0);
                for (int k = 0; k < 8; k++)
                    queue_request(FUNC_LOOKUP,
                                  probe_near(FILL_REGION |
                                             ADDR_W'($urandom_range(0, FILL_COUNT - 1)
                                                     << HASH_SHIFT)),
                                  '0, '0, '0);
                for (int k = 0; k < FILL_COUNT; k++)
                    queue_request(FUNC_UNREGISTER, FILL_REGION | ADDR_W'(k << HASH_SHIFT) | 9,
                                  '0, '0, '0);
            end

            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                base = ($urandom_range(0, 19) == 0) ? random_address() : pooled_base();
                if ($urandom_range(0, 29) == 0)
                    base = '0;
                queue_request(FUNC_REGISTER, base, random_length(),
                              TAG_W'($urandom()), TAG_W'($urandom()));
            end
            else if (roll < 55)
            begin
                base = ($urandom_range(0, 9) == 0) ? random_address() : pooled_base();
                if ($urandom_range(0, 29) == 0)
                    base = '0;
                queue_request(FUNC_UNREGISTER, base, LEN_W'({$urandom(), $urandom()}),
                              TAG_W'($urandom()), TAG_W'($urandom()));
            end
            else if (roll < 88)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    base = probe_near(pooled_base());
                else if (roll < 75)
                    base = pooled_base();
                else if (roll < 95)
                    base = random_address();
                else
                    base = '0;
                queue_request(FUNC_LOOKUP, base, LEN_W'({$urandom(), $urandom()}),
                              TAG_W'($urandom()), TAG_W'($urandom()));
            end
            else if (roll < 93)
                queue_request(FUNC_NOP, random_address(), LEN_W'({$urandom(), $urandom()}),
                              TAG_W'($urandom()), TAG_W'($urandom()));
            else
                queue_request(FUNC_W'($urandom_range(0, 3)), random_address(),
                              LEN_W'({$urandom(), $urandom()}),
                              TAG_W'($urandom()), TAG_W'($urandom()));
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() != 0 || accepted_count != issued_count)
            @(posedge clk);
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("address_range_directory_core regression: pass");
        else
            $display("address_range_directory_core regression: fail");
        $finish;
    end

endmodule

// ===== address_range_directory_core.f =====
hdl/ard_pkg.sv
hdl/ard_ram.sv
hdl/address_range_directory_core.sv
dv/tb_address_range_directory_core.sv
